// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define AST_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/nsp_pkg.sv =====
// Types, codes and helpers for the NMEA sentence parser.
package nsp_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;

  localparam logic [7:0] MAX_LEN_RESET = 8'd80;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_READ = 3'd1,
    PH_CKHI = 3'd2,
    PH_CKLO = 3'd3,
    PH_CR   = 3'd4,
    PH_LF   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ABORT_OVERFLOW = 2'd0,
    ABORT_NO_CR    = 2'd1,
    ABORT_NO_LF    = 2'd2,
    ABORT_RESTART  = 2'd3
  } abort_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_char;
    logic [7:0] payload_index;
    logic       sentence_start;
    logic       sentence_done;
    logic       checksum_ok;
    logic [7:0] sentence_length;
    logic       sentence_abort;
    logic [1:0] abort_reason;
  } result_t;

  typedef struct packed {
    logic       err;
    logic [3:0] val;
  } nibble_t;

  // Hex digit decode; anything else reads as zero with err set.
  function automatic nibble_t hex_nibble(input logic [7:0] c);
    nibble_t n;
    n.err = 1'b0;
    n.val = 4'd0;
    case (c) inside
      [8'h30:8'h39]: n.val = c[3:0];
      [8'h41:8'h46],
      [8'h61:8'h66]: n.val = c[3:0] + 4'd9;
      default: n.err = 1'b1;
    endcase
    return n;
  endfunction

endpackage

// ===== design/nsp_channels.sv =====
// Handshake channels: received characters in, parse results out.
interface nsp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink (input valid, input rx_char, output ready);
endinterface

interface nsp_result_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_char;
  logic [7:0] payload_index;
  logic       sentence_start;
  logic       sentence_done;
  logic       checksum_ok;
  logic [7:0] sentence_length;
  logic       sentence_abort;
  logic [1:0] abort_reason;

  modport source (
    output valid, input ready,
    output payload_valid, output payload_char, output payload_index,
    output sentence_start, output sentence_done, output checksum_ok,
    output sentence_length, output sentence_abort, output abort_reason
  );
  modport sink (
    input valid, output ready,
    input payload_valid, input payload_char, input payload_index,
    input sentence_start, input sentence_done, input checksum_ok,
    input sentence_length, input sentence_abort, input abort_reason
  );
endinterface

// ===== design/nsp_in_reg.sv =====
// Input register: holds one received character until the parser takes it.
module nsp_in_reg (
  input  logic     clk,
  input  logic     rst,
  nsp_char_if.sink up,
  input  logic     take,
  output logic     valid,
  output logic [7:0] rx_char
);

  assign up.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up.ready) begin
      valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      rx_char <= up.rx_char;
    end
  end

endmodule

// ===== design/nsp_parser.sv =====
// Sentence state, config register and per-character parse step.
module nsp_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata,
  input  logic           step,
  input  logic [7:0]     rx_char,
  output nsp_pkg::result_t res
);

  nsp_pkg::phase_t phase, phase_next;
  logic [7:0]      count, count_next;
  logic [7:0]      xsum, xsum_next;
  logic            hex_err, hex_err_next;
  logic [7:0]      max_len;
  nsp_pkg::nibble_t nib;

  assign nib = nsp_pkg::hex_nibble(rx_char);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= nsp_pkg::MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= nsp_pkg::PH_WAIT;
      count   <= 8'd0;
      xsum    <= 8'd0;
      hex_err <= 1'b0;
    end else if (step) begin
      phase   <= phase_next;
      count   <= count_next;
      xsum    <= xsum_next;
      hex_err <= hex_err_next;
    end
  end

  always_comb begin
    res          = '0;
    phase_next   = phase;
    count_next   = count;
    xsum_next    = xsum;
    hex_err_next = hex_err;
    if (rx_char == nsp_pkg::CHAR_DOLLAR) begin
      if (phase inside {nsp_pkg::PH_READ, nsp_pkg::PH_CKHI, nsp_pkg::PH_CKLO,
                        nsp_pkg::PH_CR, nsp_pkg::PH_LF}) begin
        res.sentence_abort  = 1'b1;
        res.abort_reason    = nsp_pkg::ABORT_RESTART;
        res.sentence_length = count;
      end
      res.sentence_start = 1'b1;
      phase_next   = nsp_pkg::PH_READ;
      count_next   = 8'd0;
      xsum_next    = 8'd0;
      hex_err_next = 1'b0;
    end else begin
      case (phase)
        nsp_pkg::PH_READ: begin
          if (rx_char == nsp_pkg::CHAR_STAR) begin
            phase_next = nsp_pkg::PH_CKHI;
          end else if (count == max_len) begin
            res.sentence_abort  = 1'b1;
            res.abort_reason    = nsp_pkg::ABORT_OVERFLOW;
            res.sentence_length = count;
            phase_next = nsp_pkg::PH_WAIT;
          end else begin
            res.payload_valid = 1'b1;
            res.payload_char  = rx_char;
            res.payload_index = count;
            count_next = count + 8'd1;
            xsum_next  = xsum ^ rx_char;
          end
        end
        nsp_pkg::PH_CKHI: begin
          xsum_next    = xsum ^ {nib.val, 4'd0};
          hex_err_next = hex_err | nib.err;
          phase_next   = nsp_pkg::PH_CKLO;
        end
        nsp_pkg::PH_CKLO: begin
          xsum_next    = xsum ^ {4'd0, nib.val};
          hex_err_next = hex_err | nib.err;
          phase_next   = nsp_pkg::PH_CR;
        end
        nsp_pkg::PH_CR: begin
          if (rx_char == nsp_pkg::CHAR_CR) begin
            phase_next = nsp_pkg::PH_LF;
          end else begin
            res.sentence_abort  = 1'b1;
            res.abort_reason    = nsp_pkg::ABORT_NO_CR;
            res.sentence_length = count;
            phase_next = nsp_pkg::PH_WAIT;
          end
        end
        nsp_pkg::PH_LF: begin
          if (rx_char == nsp_pkg::CHAR_LF) begin
            res.sentence_done = 1'b1;
            // payload XOR folded with the received sum must cancel to zero
            res.checksum_ok   = (xsum == 8'd0) && !hex_err;
          end else begin
            res.sentence_abort = 1'b1;
            res.abort_reason   = nsp_pkg::ABORT_NO_LF;
          end
          res.sentence_length = count;
          phase_next = nsp_pkg::PH_WAIT;
        end
        default: begin
          phase_next = nsp_pkg::PH_WAIT;
        end
      endcase
    end
  end

endmodule

// ===== design/nsp_out_reg.sv =====
// Result register: holds one parse result until the sink takes it.
module nsp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  nsp_pkg::result_t res,
  output logic             can_load,
  nsp_result_if.source     dn
);

  logic             valid;
  nsp_pkg::result_t res_q;

  assign can_load = !valid || dn.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_q <= res;
    end
  end

  assign dn.valid           = valid;
  assign dn.payload_valid   = res_q.payload_valid;
  assign dn.payload_char    = res_q.payload_char;
  assign dn.payload_index   = res_q.payload_index;
  assign dn.sentence_start  = res_q.sentence_start;
  assign dn.sentence_done   = res_q.sentence_done;
  assign dn.checksum_ok     = res_q.checksum_ok;
  assign dn.sentence_length = res_q.sentence_length;
  assign dn.sentence_abort  = res_q.sentence_abort;
  assign dn.abort_reason    = res_q.abort_reason;

endmodule

// ===== design/nmea_sentence_parser_core.sv =====
// NMEA 0183 sentence parser. Takes one received character per item and returns
// exactly one result item for each: payload characters with their index, a
// start flag on '$', and on the closing LF a done flag with the payload length
// and checksum_ok; overflow past max_payload_length, a missing CR or LF, or a
// '$' mid-sentence abandons the sentence with an abort reason. Throughput is
// one item per cycle when not stalled; the input register feeds the parse step
// into the result register. char_chan.ready drops only while a result waits
// on a stalled result_chan. Write max_payload_length only while idle.
module nmea_sentence_parser_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata,
  nsp_char_if.sink     char_chan,
  nsp_result_if.source result_chan
);

  logic             char_valid;
  logic [7:0]       char_q;
  logic             can_load;
  logic             step;
  nsp_pkg::result_t res;

  assign step = char_valid && can_load;

  nsp_in_reg u_in (
    .clk     (clk),
    .rst     (rst),
    .up      (char_chan),
    .take    (can_load),
    .valid   (char_valid),
    .rx_char (char_q)
  );

  nsp_parser u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .rx_char   (char_q),
    .res       (res)
  );

  nsp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (char_valid),
    .res      (res),
    .can_load (can_load),
    .dn       (result_chan)
  );

endmodule

// ===== design/nsp_checker.sv =====
// Port-level checks for the NMEA sentence parser, bound to the top level.
`include "assert_macros.svh"

module nsp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       payload_valid,
  input logic [7:0] payload_char,
  input logic       sentence_start,
  input logic       sentence_done,
  input logic       checksum_ok,
  input logic       sentence_abort,
  input logic [1:0] abort_reason
);

  `AST_NXT(a_hold, clk, rst, out_valid && !out_ready,
           out_valid && $stable(payload_char) && $stable(sentence_done),
           "stalled result item changed")
  `AST_IMP(a_payload_alone, clk, rst, out_valid && payload_valid,
           !sentence_start && !sentence_done && !sentence_abort,
           "payload item also flags a sentence event")
  `AST_IMP(a_ck_with_done, clk, rst, out_valid && checksum_ok, sentence_done,
           "checksum_ok without sentence_done")
  `AST_IMP(a_reason_with_abort, clk, rst, out_valid && (abort_reason != 2'd0),
           sentence_abort && !sentence_done, "abort reason without abort")

endmodule

bind nmea_sentence_parser_core nsp_checker u_nsp_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result_chan.valid),
  .out_ready      (result_chan.ready),
  .payload_valid  (result_chan.payload_valid),
  .payload_char   (result_chan.payload_char),
  .sentence_start (result_chan.sentence_start),
  .sentence_done  (result_chan.sentence_done),
  .checksum_ok    (result_chan.checksum_ok),
  .sentence_abort (result_chan.sentence_abort),
  .abort_reason   (result_chan.abort_reason)
);
